/* rtl/odw_pkg.sv */
// ----------------------------------------------------------------------------
// odw_pkg
// Shared types, constants and helpers for the ordered digest window.
// ----------------------------------------------------------------------------
`default_nettype none

package odw_pkg;

    localparam int WINDOW_DEPTH = 256;

    localparam int CMD_W = 2;
    localparam int IDX_W = 32;
    localparam int DIG_W = 64;
    localparam int CAP_W = 9;
    localparam int OUT_W = 2;
    localparam int CNT_W = 32;

    localparam int WORD_W = IDX_W + DIG_W;
    localparam int ADDR_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    // slot numbers stay below min(capacity, depth)
    localparam int POS_W  = (ADDR_W < CAP_W) ? ADDR_W : CAP_W;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(256);
    localparam logic [CAP_W-1:0] CAP_LIMIT = CAP_W'(WINDOW_DEPTH > 511 ? 511 : WINDOW_DEPTH);

    localparam logic [CMD_W-1:0] CMD_NOTE  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CHECK = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    localparam logic [OUT_W-1:0] OUT_ABSENT  = 2'd0;
    localparam logic [OUT_W-1:0] OUT_AGREES  = 2'd1;
    localparam logic [OUT_W-1:0] OUT_DIFFERS = 2'd2;

    // configuration as seen by the sequencer
    typedef struct packed {
        logic             wr;   // register written this cycle: empty the window
        logic [CAP_W-1:0] cap;  // effective capacity, clamped to the depth
    } t_cfg;

    typedef struct packed {
        logic              we;
        logic              re;
        logic [ADDR_W-1:0] addr;
        logic [WORD_W-1:0] wdata;
    } t_mem_req;

    // physical slot of logical position pos; base < cap and pos < cap
    function automatic logic [POS_W-1:0] odw_wrap(input logic [POS_W-1:0] base,
                                                  input logic [CAP_W-1:0] pos,
                                                  input logic [CAP_W-1:0] cap);
        logic [CAP_W:0] sum;
        sum = (CAP_W+1)'(base) + (CAP_W+1)'(pos);
        if (sum >= (CAP_W+1)'(cap)) begin
            sum = sum - (CAP_W+1)'(cap);
        end
        return POS_W'(sum);
    endfunction

endpackage

`default_nettype wire

/* rtl/odw_ram.sv */
// ----------------------------------------------------------------------------
// odw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module odw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                         i_wdata,
    input  wire logic                                     i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* rtl/odw_ctrl.sv */
// ----------------------------------------------------------------------------
// odw_ctrl
// Command sequencer: ring pointers, note compare/append, binary search.
// ----------------------------------------------------------------------------
`default_nettype none

module odw_ctrl
    import odw_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [CMD_W-1:0]  i_command,
    input  wire logic [IDX_W-1:0]  i_sample_index,
    input  wire logic [DIG_W-1:0]  i_sample_digest,
    input  wire t_cfg              i_cfg,
    output t_mem_req               o_mem,
    input  wire logic [WORD_W-1:0] i_rd_word,
    output logic                   o_busy,
    output logic                   o_strobe,
    output logic [OUT_W-1:0]       o_check_outcome,
    output logic [CAP_W-1:0]       o_entries_held,
    output logic [CNT_W-1:0]       o_evicted_count
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_NOTE_CMP,
        S_SEARCH
    } t_state;

    t_state             r_state;
    logic [CAP_W-1:0]   r_fill;
    logic [POS_W-1:0]   r_oldest;
    logic [CNT_W-1:0]   r_evict;
    logic [IDX_W-1:0]   r_idx;
    logic [DIG_W-1:0]   r_dig;
    logic [POS_W-1:0]   r_slot;
    logic [CAP_W-1:0]   r_lo;
    logic [CAP_W-1:0]   r_hi;
    logic [CAP_W-1:0]   r_mid;
    logic               r_strobe;
    logic [OUT_W-1:0]   r_outcome;
    logic [CAP_W-1:0]   r_held;
    logic [CNT_W-1:0]   r_evicted;

    logic               accept;
    logic               win_on;
    logic               full;
    logic [POS_W-1:0]   last_slot;
    logic [POS_W-1:0]   app_slot;
    logic [CAP_W-1:0]   app_fill;
    logic [POS_W-1:0]   app_oldest;
    logic [CNT_W-1:0]   app_evict;
    logic [CAP_W-1:0]   first_mid;
    logic [IDX_W-1:0]   rd_idx;
    logic [DIG_W-1:0]   rd_dig;
    logic               hit;
    logic               go_up;
    logic [CAP_W-1:0]   n_lo;
    logic [CAP_W-1:0]   n_hi;
    logic [CAP_W:0]     mid_sum;
    logic [CAP_W-1:0]   n_mid;
    logic               more;
    logic [OUT_W-1:0]   hit_outcome;
    logic               n_strobe;

    assign accept = i_start && (r_state == S_IDLE) && !i_cfg.wr;
    assign win_on = (i_cfg.cap != '0);
    assign full   = (r_fill == i_cfg.cap);

    assign rd_idx = i_rd_word[WORD_W-1 -: IDX_W];
    assign rd_dig = i_rd_word[DIG_W-1:0];

    always_comb begin
        last_slot  = odw_wrap(r_oldest, r_fill - CAP_W'(1), i_cfg.cap);
        first_mid  = r_fill >> 1;
        // appending to a full ring reuses the oldest slot
        app_slot   = full ? r_oldest : odw_wrap(r_oldest, r_fill, i_cfg.cap);
        app_fill   = full ? r_fill : r_fill + CAP_W'(1);
        app_oldest = r_oldest;
        app_evict  = r_evict;
        if (full) begin
            app_oldest = ((CAP_W'(r_oldest) + CAP_W'(1)) == i_cfg.cap) ? '0
                         : r_oldest + POS_W'(1);
            app_evict  = (r_evict == '1) ? r_evict : r_evict + CNT_W'(1);
        end
    end

    // one probe per cycle: next midpoint is issued while this one is judged
    always_comb begin
        hit         = (rd_idx == r_idx);
        go_up       = (rd_idx < r_idx);
        n_lo        = go_up ? r_mid + CAP_W'(1) : r_lo;
        n_hi        = go_up ? r_hi : r_mid;
        mid_sum     = (CAP_W+1)'(n_lo) + (CAP_W+1)'(n_hi);
        n_mid       = mid_sum[CAP_W:1];
        more        = (n_lo < n_hi);
        hit_outcome = (rd_dig == r_dig) ? OUT_AGREES : OUT_DIFFERS;
    end

    // strobe from idle unless RAM must be read; else when compare/search ends
    always_comb begin
        n_strobe = 1'b0;
        if (!i_cfg.wr) begin
            case (r_state)
                S_IDLE: begin
                    n_strobe = accept && !(win_on && (r_fill != '0) &&
                               (i_command inside {CMD_NOTE, CMD_CHECK}));
                end
                S_NOTE_CMP: begin
                    n_strobe = 1'b1;
                end
                S_SEARCH: begin
                    n_strobe = hit || !more;
                end
                default: begin
                    n_strobe = 1'b0;
                end
            endcase
        end
    end

    always_comb begin
        o_mem.we    = 1'b0;
        o_mem.re    = 1'b0;
        o_mem.addr  = '0;
        o_mem.wdata = {r_idx, r_dig};
        case (r_state)
            S_IDLE: begin
                o_mem.wdata = {i_sample_index, i_sample_digest};
                if (accept && win_on && (r_fill != '0)) begin
                    if (i_command == CMD_NOTE) begin
                        o_mem.re   = 1'b1;
                        o_mem.addr = ADDR_W'(last_slot);
                    end else if (i_command == CMD_CHECK) begin
                        o_mem.re   = 1'b1;
                        o_mem.addr = ADDR_W'(odw_wrap(r_oldest, first_mid, i_cfg.cap));
                    end
                end else if (accept && win_on && (i_command == CMD_NOTE)) begin
                    o_mem.we   = 1'b1;
                    o_mem.addr = ADDR_W'(app_slot);
                end
            end
            S_NOTE_CMP: begin
                if (hit) begin
                    o_mem.we   = 1'b1;
                    o_mem.addr = ADDR_W'(r_slot);
                end else if (go_up) begin
                    o_mem.we   = 1'b1;
                    o_mem.addr = ADDR_W'(app_slot);
                end
            end
            S_SEARCH: begin
                if (!hit && more) begin
                    o_mem.re   = 1'b1;
                    o_mem.addr = ADDR_W'(odw_wrap(r_oldest, n_mid, i_cfg.cap));
                end
            end
            default: begin
                o_mem.we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_fill   <= '0;
            r_oldest <= '0;
            r_evict  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= n_strobe;
            if (i_cfg.wr) begin
                r_fill   <= '0;
                r_oldest <= '0;
                r_evict  <= '0;
                r_state  <= S_IDLE;
            end else begin
                case (r_state)
                    S_IDLE: begin
                        if (accept) begin
                            r_idx     <= i_sample_index;
                            r_dig     <= i_sample_digest;
                            r_slot    <= last_slot;
                            r_lo      <= '0;
                            r_hi      <= r_fill;
                            r_mid     <= first_mid;
                            r_outcome <= OUT_ABSENT;
                            case (i_command)
                                CMD_NOTE: begin
                                    r_evicted <= r_evict;
                                    if (win_on && (r_fill != '0)) begin
                                        r_held  <= r_fill;
                                        r_state <= S_NOTE_CMP;
                                    end else if (win_on) begin
                                        r_fill <= app_fill;
                                        r_held <= app_fill;
                                    end else begin
                                        r_held <= r_fill;
                                    end
                                end
                                CMD_CHECK: begin
                                    r_held    <= r_fill;
                                    r_evicted <= r_evict;
                                    if (win_on && (r_fill != '0)) begin
                                        r_state <= S_SEARCH;
                                    end
                                end
                                CMD_CLEAR: begin
                                    r_fill    <= '0;
                                    r_oldest  <= '0;
                                    r_evict   <= '0;
                                    r_held    <= '0;
                                    r_evicted <= '0;
                                end
                                default: begin
                                    r_held    <= r_fill;
                                    r_evicted <= r_evict;
                                end
                            endcase
                        end
                    end
                    S_NOTE_CMP: begin
                        // larger index appends; equal overwrites; smaller is dropped
                        if (!hit && go_up) begin
                            r_fill    <= app_fill;
                            r_oldest  <= app_oldest;
                            r_evict   <= app_evict;
                            r_held    <= app_fill;
                            r_evicted <= app_evict;
                        end
                        r_state <= S_IDLE;
                    end
                    S_SEARCH: begin
                        if (hit) begin
                            r_outcome <= hit_outcome;
                            r_state   <= S_IDLE;
                        end else if (more) begin
                            r_lo  <= n_lo;
                            r_hi  <= n_hi;
                            r_mid <= n_mid;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                    default: begin
                        r_state <= S_IDLE;
                    end
                endcase
            end
        end
    end

    assign o_busy          = (r_state != S_IDLE);
    assign o_strobe        = r_strobe;
    assign o_check_outcome = r_outcome;
    assign o_entries_held  = r_held;
    assign o_evicted_count = r_evicted;

`ifndef SYNTHESIS
    a_fill_le_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= i_cfg.cap)
        else $error("fill count above capacity");

    a_oldest_in_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_oldest == '0) || (CAP_W'(r_oldest) < i_cfg.cap))
        else $error("oldest slot outside ring");

    a_search_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEARCH) |-> ((r_lo < r_hi) && (r_hi <= r_fill) && (r_mid < r_hi)))
        else $error("search interval corrupt");

    a_note_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_NOTE_CMP) |=> (r_state == S_IDLE) && (r_strobe || $past(i_cfg.wr)))
        else $error("note compare did not finish");

    a_no_write_in_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEARCH) |-> !o_mem.we)
        else $error("memory write during search");
`endif

endmodule

`default_nettype wire

/* rtl/ordered_digest_window.sv */
// ----------------------------------------------------------------------------
// ordered_digest_window
// Sliding window of (index, digest) pairs in a RAM ring with binary search.
// ----------------------------------------------------------------------------
// Timing: clear, unused commands and notes/checks on an empty or disabled
//   window strobe in the cycle after start; a note strobes after its compare
//   state; a check after up to floor(log2(entries)) + 1 search probes.
// Throughput: one command at a time, one search probe per cycle; busy is high
//   from the cycle after a RAM-reading start to the strobe; results can't stall.
// Reset (synchronous): window empty, counter zero, capacity 256; RAM not cleared.
`default_nettype none

module ordered_digest_window
    import odw_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire logic [CMD_W-1:0] i_command,
    input  wire logic [IDX_W-1:0] i_sample_index,
    input  wire logic [DIG_W-1:0] i_sample_digest,
    input  wire logic             i_cfg_we,
    input  wire logic [CAP_W-1:0] i_cfg_wdata,
    output logic                  o_strobe,
    output logic [OUT_W-1:0]      o_check_outcome,
    output logic [CAP_W-1:0]      o_entries_held,
    output logic [CNT_W-1:0]      o_evicted_count
);

    logic [CAP_W-1:0]  r_capacity;
    t_cfg              cfg;
    t_mem_req          mem_req;
    logic [WORD_W-1:0] rd_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (i_cfg_we) begin
            r_capacity <= i_cfg_wdata;
        end
    end

    assign cfg.wr  = i_cfg_we;
    assign cfg.cap = (r_capacity > CAP_LIMIT) ? CAP_LIMIT : r_capacity;

    odw_ram #(
        .WIDTH (WORD_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_req.we),
        .i_waddr (mem_req.addr),
        .i_wdata (mem_req.wdata),
        .i_re    (mem_req.re),
        .i_raddr (mem_req.addr),
        .o_rdata (rd_word)
    );

    odw_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_command       (i_command),
        .i_sample_index  (i_sample_index),
        .i_sample_digest (i_sample_digest),
        .i_cfg           (cfg),
        .o_mem           (mem_req),
        .i_rd_word       (rd_word),
        .o_busy          (busy),
        .o_strobe        (o_strobe),
        .o_check_outcome (o_check_outcome),
        .o_entries_held  (o_entries_held),
        .o_evicted_count (o_evicted_count)
    );

endmodule

`default_nettype wire

/* bench/odw_window_checker.sv */
// ----------------------------------------------------------------------------
// odw_window_checker
// Watches the command, configuration and result channels of the ordered
// digest window, predicts each reply from its own copy of the window and
// compares every strobed result against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module odw_window_checker
    import odw_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    input  wire logic             busy,
    input  wire logic [CMD_W-1:0] i_command,
    input  wire logic [IDX_W-1:0] i_sample_index,
    input  wire logic [DIG_W-1:0] i_sample_digest,
    input  wire logic             i_cfg_we,
    input  wire logic [CAP_W-1:0] i_cfg_wdata,
    input  wire logic             o_strobe,
    input  wire logic [OUT_W-1:0] o_check_outcome,
    input  wire logic [CAP_W-1:0] o_entries_held,
    input  wire logic [CNT_W-1:0] o_evicted_count,
    output int                    err_count,
    output int                    outstanding
);

    typedef struct packed {
        logic [OUT_W-1:0] outcome;
        logic [CAP_W-1:0] held;
        logic [CNT_W-1:0] evicted;
    } t_window_reply;

    t_window_reply replies_due[$];

    logic [IDX_W-1:0] slot_index  [WINDOW_DEPTH];
    logic [DIG_W-1:0] slot_digest [WINDOW_DEPTH];
    int unsigned      oldest;
    int unsigned      fill;
    logic [CNT_W-1:0] evictions;
    logic [CAP_W-1:0] capacity;
    int               shown;

    initial begin
        err_count   = 0;
        outstanding = 0;
        shown       = 0;
        oldest      = 0;
        fill        = 0;
        evictions   = '0;
        capacity    = CAP_RESET;
    end

    function automatic int unsigned live_capacity();
        int unsigned c;
        c = capacity;
        return (c > WINDOW_DEPTH) ? WINDOW_DEPTH : c;
    endfunction

    function automatic int unsigned slot_of(int unsigned pos, int unsigned cap);
        return (oldest + pos) % cap;
    endfunction

    function automatic void empty_window();
        oldest    = 0;
        fill      = 0;
        evictions = '0;
    endfunction

    function automatic void note_sample(logic [IDX_W-1:0] idx, logic [DIG_W-1:0] dig);
        int unsigned cap;
        int unsigned p;
        cap = live_capacity();
        if (cap == 0) begin
            return;
        end
        if (fill > cap) begin
            fill = cap;
        end
        if (fill > 0) begin
            p = slot_of(fill - 1, cap);
            // tie with the newest entry refreshes its digest; older index is dropped
            if (idx == slot_index[p]) begin
                slot_digest[p] = dig;
                return;
            end
            if (idx < slot_index[p]) begin
                return;
            end
        end
        if (fill == cap) begin
            oldest = (oldest + 1) % cap;
            fill   = fill - 1;
            if (evictions != '1) begin
                evictions = evictions + 1'b1;
            end
        end
        p              = slot_of(fill, cap);
        slot_index[p]  = idx;
        slot_digest[p] = dig;
        fill           = fill + 1;
    endfunction

    function automatic logic [OUT_W-1:0] search_sample(logic [IDX_W-1:0] idx,
                                                       logic [DIG_W-1:0] dig);
        int unsigned cap;
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        int unsigned p;
        cap = live_capacity();
        if (cap == 0 || fill == 0) begin
            return OUT_ABSENT;
        end
        lo = 0;
        hi = (fill > cap) ? cap : fill;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            p   = slot_of(mid, cap);
            if (slot_index[p] == idx) begin
                return (slot_digest[p] == dig) ? OUT_AGREES : OUT_DIFFERS;
            end
            if (slot_index[p] < idx) begin
                lo = mid + 1;
            end else begin
                hi = mid;
            end
        end
        return OUT_ABSENT;
    endfunction

    function automatic t_window_reply apply_command(logic [CMD_W-1:0] cmd,
                                                    logic [IDX_W-1:0] idx,
                                                    logic [DIG_W-1:0] dig);
        t_window_reply r;
        r.outcome = OUT_ABSENT;
        case (cmd)
            CMD_NOTE:  note_sample(idx, dig);
            CMD_CHECK: r.outcome = search_sample(idx, dig);
            CMD_CLEAR: empty_window();
            default: ;
        endcase
        r.held    = CAP_W'(fill);
        r.evicted = evictions;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_window_reply want;
        if (!i_rst_n) begin
            replies_due.delete();
            empty_window();
            capacity = CAP_RESET;
        end else begin
            if (o_strobe) begin
                if (replies_due.size() == 0) begin
                    err_count = err_count + 1;
                    if (shown < 10) begin
                        $display("%0t: unexpected result: outcome %0d held %0d evicted %0d",
                                 $realtime, o_check_outcome, o_entries_held, o_evicted_count);
                    end
                    shown = shown + 1;
                end else begin
                    want = replies_due.pop_front();
                    if (o_check_outcome !== want.outcome || o_entries_held !== want.held ||
                        o_evicted_count !== want.evicted) begin
                        err_count = err_count + 1;
                        if (shown < 10) begin
                            $display("%0t: mismatch, expected outcome %0d held %0d evicted %0d",
                                     $realtime, want.outcome, want.held, want.evicted);
                            $display("    actual outcome %0d held %0d evicted %0d",
                                     o_check_outcome, o_entries_held, o_evicted_count);
                        end
                        shown = shown + 1;
                    end
                end
            end
            if (i_cfg_we) begin
                capacity = i_cfg_wdata;
                empty_window();
            end
            if (start && !busy) begin
                replies_due.push_back(apply_command(i_command, i_sample_index,
                                                    i_sample_digest));
            end
        end
        outstanding = replies_due.size();
    end

endmodule

`default_nettype wire

/* bench/tb_ordered_digest_window.sv */
// ----------------------------------------------------------------------------
// tb_ordered_digest_window
// Drives the ordered digest window with directed corner commands and then
// long runs of ascending notes, checks, clears and noise across a sweep of
// window capacities; the checker beside the block judges every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module tb_ordered_digest_window;
    import odw_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED  = 2'd3;
    localparam int               CYCLE_LIMIT = 400000;
    localparam int               PHASES      = 10;

    logic             i_clk;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    logic [CMD_W-1:0] i_command;
    logic [IDX_W-1:0] i_sample_index;
    logic [DIG_W-1:0] i_sample_digest;
    logic             i_cfg_we;
    logic [CAP_W-1:0] i_cfg_wdata;
    logic             o_strobe;
    logic [OUT_W-1:0] o_check_outcome;
    logic [CAP_W-1:0] o_entries_held;
    logic [CNT_W-1:0] o_evicted_count;

    int               err_count;
    int               outstanding;
    int               cycle_count;

    // generator state: newest index noted and a short memory of noted pairs
    logic [IDX_W-1:0] tail_idx;
    logic [IDX_W-1:0] memo_idx [16];
    logic [DIG_W-1:0] memo_dig [16];
    int               memo_n;
    int               memo_wr;
    logic             steady;

    ordered_digest_window DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_command       (i_command),
        .i_sample_index  (i_sample_index),
        .i_sample_digest (i_sample_digest),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .o_strobe        (o_strobe),
        .o_check_outcome (o_check_outcome),
        .o_entries_held  (o_entries_held),
        .o_evicted_count (o_evicted_count)
    );

    odw_window_checker u_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_command       (i_command),
        .i_sample_index  (i_sample_index),
        .i_sample_digest (i_sample_digest),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .o_strobe        (o_strobe),
        .o_check_outcome (o_check_outcome),
        .o_entries_held  (o_entries_held),
        .o_evicted_count (o_evicted_count),
        .err_count       (err_count),
        .outstanding     (outstanding)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic logic [DIG_W-1:0] rand_digest();
        return {$urandom, $urandom};
    endfunction

    function automatic void remember(logic [IDX_W-1:0] idx, logic [DIG_W-1:0] dig);
        memo_idx[memo_wr] = idx;
        memo_dig[memo_wr] = dig;
        memo_wr = (memo_wr + 1) % 16;
        if (memo_n < 16) begin
            memo_n = memo_n + 1;
        end
    endfunction

    function automatic void fresh_base();
        tail_idx = $urandom >> $urandom_range(0, 31);
        memo_n   = 0;
        memo_wr  = 0;
    endfunction

    // called at a rising edge; returns at the edge where the transfer happens
    task automatic issue(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
                         input logic [DIG_W-1:0] dig);
        if (!steady) begin
            while ($urandom_range(0, 99) < 21) begin
                start <= 1'b0;
                @(posedge i_clk);
            end
        end
        start           <= 1'b1;
        i_command       <= cmd;
        i_sample_index  <= idx;
        i_sample_digest <= dig;
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
    endtask

    // register write only once every outstanding result has come back
    task automatic set_capacity(input logic [CAP_W-1:0] cap);
        start <= 1'b0;
        do begin
            @(negedge i_clk);
        end while (outstanding != 0);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= cap;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        fresh_base();
    endtask

    task automatic random_op();
        int               pick;
        int               k;
        logic [DIG_W-1:0] dig;
        logic [IDX_W-1:0] idx;
        pick = $urandom_range(0, 99);
        dig  = rand_digest();
        if (pick < 45) begin
            if ($urandom_range(0, 19) == 0) begin
                tail_idx = tail_idx + $urandom;
            end else begin
                tail_idx = tail_idx + $urandom_range(1, 3);
            end
            issue(CMD_NOTE, tail_idx, dig);
            remember(tail_idx, dig);
        end else if (pick < 50) begin
            issue(CMD_NOTE, tail_idx, dig);
            remember(tail_idx, dig);
        end else if (pick < 54) begin
            issue(CMD_NOTE, tail_idx - $urandom_range(1, 1000), dig);
        end else if (pick < 90 && memo_n > 0) begin
            k = $urandom_range(0, memo_n - 1);
            idx = memo_idx[k];
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                dig = memo_dig[k];
            end else if (pick < 85) begin
                dig = memo_dig[k] ^ (64'd1 << $urandom_range(0, 63));
            end else begin
                idx = idx + ($urandom_range(0, 1) ? 32'd1 : 32'hFFFF_FFFF);
            end
            issue(CMD_CHECK, idx, dig);
        end else if (pick < 96) begin
            issue(CMD_CHECK, $urandom, dig);
        end else if (pick < 98) begin
            issue(CMD_CLEAR, $urandom, dig);
            fresh_base();
        end else begin
            issue(CMD_UNUSED, $urandom, dig);
        end
    endtask

    function automatic logic [CAP_W-1:0] phase_capacity(int ph);
        case (ph)
            0:       return CAP_RESET;
            1:       return 9'd0;
            2:       return 9'd1;
            3:       return 9'd2;
            4:       return 9'd3;
            5:       return 9'd16;
            6:       return 9'd255;
            7:       return 9'd257;
            8:       return 9'd511;
            default: return CAP_W'($urandom_range(0, 511));
        endcase
    endfunction

    initial begin
        int               ph;
        int               n;
        int               items;
        logic [CAP_W-1:0] cap;

        i_clk           = 1'b0;
        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_command       = CMD_NOTE;
        i_sample_index  = '0;
        i_sample_digest = '0;
        i_cfg_we        = 1'b0;
        i_cfg_wdata     = '0;
        cycle_count     = 0;
        steady          = 1'b0;
        memo_n          = 0;
        memo_wr         = 0;
        tail_idx        = '0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // corners at the reset capacity
        issue(CMD_NOTE,  32'd0, 64'd0);
        issue(CMD_NOTE,  32'd0, '1);                      // tie overwrites digest
        issue(CMD_CHECK, 32'd0, '1);
        issue(CMD_CHECK, 32'd0, 64'd0);
        issue(CMD_NOTE,  32'hFFFF_FFFF, 64'hA5A5_5A5A_A5A5_5A5A);
        issue(CMD_NOTE,  32'd7, 64'h1234);                 // older index, dropped
        issue(CMD_CHECK, 32'd7, 64'h1234);
        issue(CMD_CHECK, 32'hFFFF_FFFF, 64'hA5A5_5A5A_A5A5_5A5A);
        issue(CMD_CHECK, 32'h8000_0000, 64'd0);
        issue(CMD_UNUSED, '1, '1);
        issue(CMD_CLEAR, 32'd0, 64'd0);
        issue(CMD_CHECK, 32'd0, 64'd0);
        issue(CMD_NOTE,  32'd3, 64'h5A5A_A5A5_5A5A_A5A5);
        // disabled window
        set_capacity(9'd0);
        issue(CMD_NOTE,  32'd1, 64'd1);
        issue(CMD_CHECK, 32'd1, 64'd1);
        // one-entry window evicts on every append
        set_capacity(9'd1);
        issue(CMD_NOTE,  32'd10, 64'd10);
        issue(CMD_NOTE,  32'd20, 64'd20);
        issue(CMD_CHECK, 32'd10, 64'd10);
        issue(CMD_CHECK, 32'd20, 64'd20);
        // register above the ring depth
        set_capacity(9'd257);
        issue(CMD_NOTE,  32'd5, 64'd5);
        issue(CMD_CHECK, 32'd5, 64'd5);

        for (ph = 0; ph < PHASES; ph++) begin
            cap = phase_capacity(ph);
            set_capacity(cap);
            items = (ph == 0) ? 300 : (cap == 0) ? 60 : (cap < 20) ? 150 : 200;
            for (n = 0; n < items; n++) begin
                steady = (ph == 0 && n >= 50 && n < 250);
                random_op();
            end
            steady = 1'b0;
        end

        start <= 1'b0;
        do begin
            @(negedge i_clk);
        end while (outstanding != 0);
        repeat (12) @(negedge i_clk);

        if (err_count == 0 && outstanding == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

`default_nettype wire
